>>> src/kts_pkg.sv
// kts_pkg: shared constants, codes and control structs of the topological sorter
// used by kts_graph_mem, kts_sort_mem and the top level; no dependencies
package kts_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;

	localparam int KIND_W   = 2;
	localparam int VID_W    = 6;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 7;

	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SORT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CYCLE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SORTED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

	typedef struct packed {
		logic head_we;
		logic edge_we;
		logic deg_we;
		logic clear;
	} graph_req_t;

	typedef struct packed {
		logic wdeg_we;
		logic q_we;
	} sort_req_t;

endpackage

>>> src/kts_step_unit.sv
// kts_step_unit: shared increment / decrement unit for degree counts
// depends on nothing but its width parameter
module kts_step_unit #(
	parameter int DW = 9
) (
	input  logic [DW-1:0] a,
	input  logic          dec,
	output logic [DW-1:0] y,
	output logic          a_zero,
	output logic          a_one
);

	assign y      = dec ? (a - DW'(1)) : (a + DW'(1));
	assign a_zero = (a == '0);
	assign a_one  = (a == DW'(1));

endmodule

>>> src/kts_graph_mem.sv
// kts_graph_mem: list heads, edge target/link store and in-degree store
// depends on kts_pkg for the request struct
module kts_graph_mem #(
	parameter int V   = 64,
	parameter int E   = 256,
	parameter int VAW = 6,
	parameter int EAW = 8,
	parameter int ECW = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kts_pkg::graph_req_t req,
	input  logic [VAW-1:0]     head_raddr,
	input  logic [VAW-1:0]     head_waddr,
	input  logic [ECW-1:0]     head_wdata,
	input  logic [EAW-1:0]     edge_raddr,
	input  logic [EAW-1:0]     edge_waddr,
	input  logic [VAW-1:0]     tgt_wdata,
	input  logic [ECW-1:0]     link_wdata,
	input  logic [VAW-1:0]     deg_raddr,
	input  logic [VAW-1:0]     deg_waddr,
	input  logic [ECW-1:0]     deg_wdata,
	output logic [ECW-1:0]     head_rdata,
	output logic [VAW-1:0]     tgt_rdata,
	output logic [ECW-1:0]     link_rdata,
	output logic [ECW-1:0]     deg_rdata
);

	logic [ECW-1:0] head_mem [V];
	logic [ECW-1:0] deg_mem  [V];
	logic [VAW-1:0] tgt_mem  [E];
	logic [ECW-1:0] link_mem [E];

	logic [V-1:0]   head_vld_q;
	logic [V-1:0]   deg_vld_q;
	logic           head_rvld_q;
	logic           deg_rvld_q;
	logic [ECW-1:0] head_rd_q;
	logic [ECW-1:0] deg_rd_q;

	// valid bits stand in for the reset value of heads and degrees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= '0;
			deg_vld_q   <= '0;
			head_rvld_q <= 1'b0;
			deg_rvld_q  <= 1'b0;
		end else begin
			head_rvld_q <= head_vld_q[head_raddr];
			deg_rvld_q  <= deg_vld_q[deg_raddr];
			if (req.clear) begin
				head_vld_q <= '0;
				deg_vld_q  <= '0;
			end else begin
				if (req.head_we) head_vld_q[head_waddr] <= 1'b1;
				if (req.deg_we)  deg_vld_q[deg_waddr]   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		head_rd_q  <= head_mem[head_raddr];
		deg_rd_q   <= deg_mem[deg_raddr];
		tgt_rdata  <= tgt_mem[edge_raddr];
		link_rdata <= link_mem[edge_raddr];
		if (req.head_we) head_mem[head_waddr] <= head_wdata;
		if (req.deg_we)  deg_mem[deg_waddr]   <= deg_wdata;
		if (req.edge_we) begin
			tgt_mem[edge_waddr]  <= tgt_wdata;
			link_mem[edge_waddr] <= link_wdata;
		end
	end

	assign head_rdata = head_rvld_q ? head_rd_q : ECW'(E);
	assign deg_rdata  = deg_rvld_q ? deg_rd_q : '0;

endmodule

>>> src/kts_sort_mem.sv
// kts_sort_mem: working degrees and ready queue of one sort run
// depends on kts_pkg for the request struct
module kts_sort_mem #(
	parameter int V   = 64,
	parameter int VAW = 6,
	parameter int ECW = 9
) (
	input  logic              clk,
	input  kts_pkg::sort_req_t req,
	input  logic [VAW-1:0]    wdeg_raddr,
	input  logic [VAW-1:0]    wdeg_waddr,
	input  logic [ECW-1:0]    wdeg_wdata,
	input  logic [VAW-1:0]    q_raddr,
	input  logic [VAW-1:0]    q_waddr,
	input  logic [VAW-1:0]    q_wdata,
	output logic [ECW-1:0]    wdeg_rdata,
	output logic [VAW-1:0]    q_rdata
);

	logic [ECW-1:0] wdeg_mem [V];
	logic [VAW-1:0] q_mem    [V];

	always_ff @(posedge clk) begin
		wdeg_rdata <= wdeg_mem[wdeg_raddr];
		q_rdata    <= q_mem[q_raddr];
		if (req.wdeg_we) wdeg_mem[wdeg_waddr] <= wdeg_wdata;
		if (req.q_we)    q_mem[q_waddr]       <= q_wdata;
	end

endmodule

>>> src/kahn_topological_sorter_top.sv
// kahn_topological_sorter_top: command front end and sort sequencer
// depends on kts_pkg, kts_step_unit, kts_graph_mem and kts_sort_mem
//
//  channel   handshake           payload
//  command   start / busy        kind, src_vertex, dst_vertex
//  result    strobe (one cycle)  status, vertex, last
//  config    cfg_we              cfg_wdata (vertex count)
//
// add edge: rejected from S_IDLE, or stored as head and degree read, then write (S_ADD_WR)
// clear and config write: list heads and degrees drop through per-entry valid bits
// sort: seed each vertex (read, write), pop each and read its head, walk each out-edge,
//   close the walk, then read out each vertex (one port per store, one step unit)
// busy rises the cycle after a multi-cycle command is accepted and falls as its last beat shows
// reset leaves an empty graph and a vertex count equal to MAX_VERTICES; results cannot stall
module kahn_topological_sorter_top #(
	parameter int MAX_VERTICES = kts_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = kts_pkg::MAX_EDGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [kts_pkg::KIND_W-1:0]   kind,
	input  logic [kts_pkg::VID_W-1:0]    src_vertex,
	input  logic [kts_pkg::VID_W-1:0]    dst_vertex,
	input  logic                         cfg_we,
	input  logic [kts_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                         strobe,
	output logic [kts_pkg::STATUS_W-1:0] status,
	output logic [kts_pkg::VID_W-1:0]    vertex,
	output logic                         last
);

	localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_WR, S_INIT_RD, S_INIT_WR, S_POP, S_POP_WAIT, S_HEAD,
		S_WALK, S_WREAD, S_DEC, S_FIN, S_OUT_RD, S_OUT_EM
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  n_q;         // effective vertex count
	logic [ECW-1:0] total_q;     // edges stored
	logic [VAW-1:0] src_q;
	logic [VAW-1:0] dst_q;
	logic [CW-1:0]  i_q;         // seed / output index
	logic [CW-1:0]  rd_q;        // queue read pointer
	logic [CW-1:0]  wr_q;        // queue write pointer
	logic [ECW-1:0] e_q;         // edge being walked
	logic [VAW-1:0] w_q;         // neighbor of that edge

	logic                strobe_q;
	logic [kts_pkg::STATUS_W-1:0] status_q;
	logic [kts_pkg::VID_W-1:0]    vertex_q;
	logic                last_q;

	kts_pkg::graph_req_t g_req;
	kts_pkg::sort_req_t  s_req;

	logic [ECW-1:0] head_rdata, link_rdata, deg_rdata, wdeg_rdata;
	logic [VAW-1:0] tgt_rdata, q_rdata;
	logic [VAW-1:0] head_raddr, deg_raddr, wdeg_waddr, q_raddr, q_wdata;
	logic [ECW-1:0] wdeg_wdata;
	logic [ECW-1:0] alu_a, alu_y;
	logic           alu_dec, alu_zero, alu_one;

	logic accept;
	logic bad_vertex;
	logic [CW-1:0] n_cfg;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	assign bad_vertex = (CW'(src_vertex) >= n_q) || (CW'(dst_vertex) >= n_q)
		|| (src_vertex >= kts_pkg::VID_W'(MAX_VERTICES - 1) + 1'b1 && MAX_VERTICES < 64)
		|| (dst_vertex >= kts_pkg::VID_W'(MAX_VERTICES - 1) + 1'b1 && MAX_VERTICES < 64);

	// count of zero acts as one, above the maximum as the maximum
	always_comb begin
		if (cfg_wdata == '0) begin
			n_cfg = CW'(1);
		end else if (cfg_wdata > kts_pkg::CFG_W'(MAX_VERTICES)) begin
			n_cfg = CW'(MAX_VERTICES);
		end else begin
			n_cfg = CW'(cfg_wdata);
		end
	end

	// shared step unit: +1 on a stored in-degree, -1 on a working degree
	assign alu_dec = (state_q == S_DEC);
	assign alu_a   = alu_dec ? wdeg_rdata : deg_rdata;

	kts_step_unit #(.DW(ECW)) u_step (
		.a      (alu_a),
		.dec    (alu_dec),
		.y      (alu_y),
		.a_zero (alu_zero),
		.a_one  (alu_one)
	);

	// memory requests follow the sequencer state
	always_comb begin
		g_req.head_we = (state_q == S_ADD_WR);
		g_req.edge_we = (state_q == S_ADD_WR);
		g_req.deg_we  = (state_q == S_ADD_WR);
		g_req.clear   = cfg_we || (accept && kind == kts_pkg::KIND_CLEAR);

		head_raddr = (state_q == S_POP_WAIT) ? q_rdata : src_vertex[VAW-1:0];
		deg_raddr  = (state_q == S_IDLE) ? dst_vertex[VAW-1:0] : i_q[VAW-1:0];

		s_req.wdeg_we = (state_q == S_INIT_WR) || (state_q == S_DEC && !alu_zero);
		wdeg_waddr    = (state_q == S_DEC) ? w_q : i_q[VAW-1:0];
		wdeg_wdata    = (state_q == S_DEC) ? alu_y : deg_rdata;

		s_req.q_we = (wr_q < CW'(MAX_VERTICES)) &&
			((state_q == S_INIT_WR && deg_rdata == '0) ||
			 (state_q == S_DEC && alu_one));
		q_wdata = (state_q == S_DEC) ? w_q : i_q[VAW-1:0];
		q_raddr = (state_q == S_POP) ? rd_q[VAW-1:0] : i_q[VAW-1:0];
	end

	kts_graph_mem #(
		.V(MAX_VERTICES), .E(MAX_EDGES), .VAW(VAW), .EAW(EAW), .ECW(ECW)
	) u_graph (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (g_req),
		.head_raddr (head_raddr),
		.head_waddr (src_q),
		.head_wdata (total_q),
		.edge_raddr (e_q[EAW-1:0]),
		.edge_waddr (total_q[EAW-1:0]),
		.tgt_wdata  (dst_q),
		.link_wdata (head_rdata),
		.deg_raddr  (deg_raddr),
		.deg_waddr  (dst_q),
		.deg_wdata  (alu_y),
		.head_rdata (head_rdata),
		.tgt_rdata  (tgt_rdata),
		.link_rdata (link_rdata),
		.deg_rdata  (deg_rdata)
	);

	kts_sort_mem #(.V(MAX_VERTICES), .VAW(VAW), .ECW(ECW)) u_sort (
		.clk        (clk),
		.req        (s_req),
		.wdeg_raddr (tgt_rdata),
		.wdeg_waddr (wdeg_waddr),
		.wdeg_wdata (wdeg_wdata),
		.q_raddr    (q_raddr),
		.q_waddr    (wr_q[VAW-1:0]),
		.q_wdata    (q_wdata),
		.wdeg_rdata (wdeg_rdata),
		.q_rdata    (q_rdata)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= CW'(MAX_VERTICES);
			total_q  <= '0;
			i_q      <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			e_q      <= '0;
			w_q      <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			strobe_q <= 1'b0;
			status_q <= kts_pkg::ST_ADDED;
			vertex_q <= '0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (s_req.q_we) wr_q <= wr_q + 1'b1;
			if (cfg_we) begin
				n_q     <= n_cfg;
				total_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						src_q <= src_vertex[VAW-1:0];
						dst_q <= dst_vertex[VAW-1:0];
						unique case (kind)
							kts_pkg::KIND_ADD: begin
								if (bad_vertex) begin
									strobe_q <= 1'b1;
									status_q <= kts_pkg::ST_INVALID;
									vertex_q <= '0;
									last_q   <= 1'b1;
								end else if (total_q == ECW'(MAX_EDGES)) begin
									strobe_q <= 1'b1;
									status_q <= kts_pkg::ST_FULL;
									vertex_q <= '0;
									last_q   <= 1'b1;
								end else begin
									state_q <= S_ADD_WR;
								end
							end
							kts_pkg::KIND_SORT: begin
								i_q     <= '0;
								rd_q    <= '0;
								wr_q    <= '0;
								state_q <= S_INIT_RD;
							end
							kts_pkg::KIND_CLEAR: begin
								total_q  <= '0;
								strobe_q <= 1'b1;
								status_q <= kts_pkg::ST_CLEARED;
								vertex_q <= '0;
								last_q   <= 1'b1;
							end
							default: begin
								// unused kind: no result
							end
						endcase
					end
				end
				S_ADD_WR: begin
					total_q  <= total_q + 1'b1;
					strobe_q <= 1'b1;
					status_q <= kts_pkg::ST_ADDED;
					vertex_q <= '0;
					last_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_INIT_RD: state_q <= S_INIT_WR;
				S_INIT_WR: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == n_q) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_INIT_RD;
					end
				end
				S_POP: begin
					if (rd_q == wr_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_POP_WAIT;
					end
				end
				S_POP_WAIT: begin
					rd_q    <= rd_q + 1'b1;
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					e_q     <= head_rdata;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (e_q >= total_q) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_WREAD;
					end
				end
				S_WREAD: begin
					w_q     <= tgt_rdata;
					e_q     <= link_rdata;
					state_q <= S_DEC;
				end
				S_DEC: state_q <= S_WALK;
				S_FIN: begin
					i_q <= '0;
					if (wr_q != n_q) begin
						strobe_q <= 1'b1;
						status_q <= kts_pkg::ST_CYCLE;
						vertex_q <= '0;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_OUT_RD;
					end
				end
				S_OUT_RD: state_q <= S_OUT_EM;
				S_OUT_EM: begin
					strobe_q <= 1'b1;
					status_q <= kts_pkg::ST_SORTED;
					vertex_q <= kts_pkg::VID_W'(q_rdata);
					last_q   <= (i_q + 1'b1 == n_q);
					i_q      <= i_q + 1'b1;
					if (i_q + 1'b1 == n_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_OUT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign vertex = vertex_q;
	assign last   = last_q;

`ifndef SYNTHESIS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= ECW'(MAX_EDGES))
		else $error("edge count above store size");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_ADD_WR) |-> (rd_q <= wr_q))
		else $error("queue read pointer passed write pointer");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q != kts_pkg::ST_SORTED) |-> last_q)
		else $error("non-sort result without last");

	a_clear_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == kts_pkg::KIND_CLEAR) |=>
		(strobe_q && status_q == kts_pkg::ST_CLEARED && total_q == '0))
		else $error("clear did not answer at once");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> (state_q == S_IDLE))
		else $error("final beat while still working");
`endif

endmodule

>>> sim/kahn_topological_sorter_top_tb.sv
// kahn_topological_sorter_top_tb: self-checking bench for the topological sorter top level
// depends on kts_pkg and kahn_topological_sorter_top; a local graph model predicts each result beat
`timescale 1ns / 100ps

module kahn_topological_sorter_top_tb;

	localparam int NV = kts_pkg::MAX_VERTICES_DEF;
	localparam int NE = kts_pkg::MAX_EDGES_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [kts_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [kts_pkg::STATUS_W-1:0] st;
		logic [kts_pkg::VID_W-1:0]    vid;
		logic                         fin;
	} beat_t;

	// directed row: either a register write or a command, with an optional typed status
	typedef struct {
		bit                           is_cfg;
		logic [kts_pkg::CFG_W-1:0]    cfg_val;
		logic [kts_pkg::KIND_W-1:0]   k;
		logic [kts_pkg::VID_W-1:0]    s;
		logic [kts_pkg::VID_W-1:0]    d;
		bit                           typed;
		logic [kts_pkg::STATUS_W-1:0] st;
	} row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic [kts_pkg::KIND_W-1:0]   kind = '0;
	logic [kts_pkg::VID_W-1:0]    src_vertex = '0;
	logic [kts_pkg::VID_W-1:0]    dst_vertex = '0;
	logic                         cfg_we = 1'b0;
	logic [kts_pkg::CFG_W-1:0]    cfg_wdata = '0;
	logic                         strobe;
	logic [kts_pkg::STATUS_W-1:0] status;
	logic [kts_pkg::VID_W-1:0]    vertex;
	logic                         last;

	kahn_topological_sorter_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.strobe(strobe), .status(status), .vertex(vertex), .last(last)
	);

	always #5 clk = ~clk;

	// graph model state at the block's widths
	logic [kts_pkg::CFG_W-1:0] count_reg;
	logic [8:0]                list_head [NV];
	logic [kts_pkg::VID_W-1:0] edge_dst [NE];
	logic [8:0]                edge_next [NE];
	logic [8:0]                edges_stored;
	logic [8:0]                in_deg [NV];

	beat_t pending_beats[$];
	int    errors = 0;
	int    beats_seen = 0;
	int    items_sent = 0;
	int    sorts_done = 0;
	int    cycles_seen = 0;
	int    gap_pct = 0;

	function automatic int active_count();
		if (count_reg == 0) return 1;
		if (count_reg > NV) return NV;
		return int'(count_reg);
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < NV; i++) begin
			list_head[i] = 9'(NE);
			in_deg[i] = '0;
		end
		edges_stored = '0;
	endfunction

	function automatic void push_beat(logic [kts_pkg::STATUS_W-1:0] st,
			logic [kts_pkg::VID_W-1:0] v, logic f);
		beat_t b;
		b.st = st;
		b.vid = v;
		b.fin = f;
		pending_beats.push_back(b);
	endfunction

	// kahn walk over the modeled lists, newest edge first
	function automatic void predict_order();
		int n;
		int wdeg [NV];
		int ready[$];
		int order[$];
		int u;
		int e;
		int steps;
		int w;
		n = active_count();
		for (int i = 0; i < n; i++) begin
			wdeg[i] = in_deg[i];
			if (wdeg[i] == 0) ready.push_back(i);
		end
		while (ready.size() > 0) begin
			u = ready.pop_front();
			order.push_back(u);
			e = list_head[u];
			steps = 0;
			while (e < edges_stored && steps < NE) begin
				w = edge_dst[e];
				if (wdeg[w] > 0) begin
					wdeg[w]--;
					if (wdeg[w] == 0) ready.push_back(w);
				end
				e = edge_next[e];
				steps++;
			end
		end
		sorts_done++;
		if (order.size() != n) begin
			push_beat(kts_pkg::ST_CYCLE, '0, 1'b1);
		end else begin
			for (int i = 0; i < n; i++)
				push_beat(kts_pkg::ST_SORTED, kts_pkg::VID_W'(order[i]), (i == n - 1));
		end
	endfunction

	function automatic void predict_command(logic [kts_pkg::KIND_W-1:0] k,
			logic [kts_pkg::VID_W-1:0] s, logic [kts_pkg::VID_W-1:0] d);
		int n;
		n = active_count();
		case (k)
			kts_pkg::KIND_ADD: begin
				if (s >= n || d >= n) begin
					push_beat(kts_pkg::ST_INVALID, '0, 1'b1);
				end else if (edges_stored >= NE) begin
					push_beat(kts_pkg::ST_FULL, '0, 1'b1);
				end else begin
					edge_dst[edges_stored] = d;
					edge_next[edges_stored] = list_head[s];
					list_head[s] = edges_stored;
					edges_stored++;
					in_deg[d]++;
					push_beat(kts_pkg::ST_ADDED, '0, 1'b1);
				end
			end
			kts_pkg::KIND_SORT: predict_order();
			kts_pkg::KIND_CLEAR: begin
				wipe_graph();
				push_beat(kts_pkg::ST_CLEARED, '0, 1'b1);
			end
			default: ; // unused kind, ignored by the block
		endcase
	endfunction

	// result monitor: every strobe beat must match the oldest pending beat
	always @(posedge clk) begin
		cycles_seen <= cycles_seen + 1;
		if (arst_n && strobe) begin
			beats_seen <= beats_seen + 1;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat status=%0d vertex=%0d last=%0d",
					$time, status, vertex, last);
				errors++;
			end else begin
				beat_t b;
				b = pending_beats.pop_front();
				if (status !== b.st) begin
					$display("%0t: status expected %0d actual %0d", $time, b.st, status);
					errors++;
				end
				if (vertex !== b.vid) begin
					$display("%0t: vertex expected %0d actual %0d", $time, b.vid, vertex);
					errors++;
				end
				if (last !== b.fin) begin
					$display("%0t: last expected %0d actual %0d", $time, b.fin, last);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles_seen > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats pending", $time, pending_beats.size());
			$display("kahn_topological_sorter_top_tb failed");
			$finish;
		end
	end

	task automatic idle_cycle();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// present one command beat and hold it until accepted; optional random gap first
	task automatic send_cmd(logic [kts_pkg::KIND_W-1:0] k, logic [kts_pkg::VID_W-1:0] s,
			logic [kts_pkg::VID_W-1:0] d);
		while ($urandom_range(99) < gap_pct) idle_cycle();
		start <= 1'b1;
		kind <= k;
		src_vertex <= s;
		dst_vertex <= d;
		do @(posedge clk); while (busy);
		predict_command(k, s, d);
		if (k != KIND_UNUSED) items_sent++;
	endtask

	task automatic drain();
		idle_cycle();
		while (pending_beats.size() > 0) @(posedge clk);
	endtask

	// register write, only with the block idle; also clears the modeled graph
	task automatic write_count(logic [kts_pkg::CFG_W-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_reg = v;
		wipe_graph();
	endtask

	// one graph: mostly acyclic edges with random content, some noise, then a sort
	task automatic graph_phase(logic [kts_pkg::CFG_W-1:0] cfg_v, bit hold_before_sort);
		int n;
		int edges;
		int a;
		int b;
		int pick;
		write_count(cfg_v);
		n = active_count();
		edges = $urandom_range((3 * n > 30) ? 30 : 3 * n);
		for (int i = 0; i < edges; i++) begin
			a = $urandom_range(n - 1);
			b = $urandom_range(n - 1);
			pick = $urandom_range(99);
			if (pick < 75) begin
				if (a > b)
					send_cmd(kts_pkg::KIND_ADD, kts_pkg::VID_W'(b), kts_pkg::VID_W'(a));
				else if (a < b)
					send_cmd(kts_pkg::KIND_ADD, kts_pkg::VID_W'(a), kts_pkg::VID_W'(b));
				else
					send_cmd(kts_pkg::KIND_ADD, kts_pkg::VID_W'(a),
						kts_pkg::VID_W'((a + 1 < n) ? a + 1 : a));
			end else if (pick < 87) begin
				send_cmd(kts_pkg::KIND_ADD, kts_pkg::VID_W'(a), kts_pkg::VID_W'(b));
			end else if (pick < 94) begin
				// random endpoint that may lie past the count, either side
				if ($urandom_range(1))
					send_cmd(kts_pkg::KIND_ADD, kts_pkg::VID_W'($urandom), kts_pkg::VID_W'(b));
				else
					send_cmd(kts_pkg::KIND_ADD, kts_pkg::VID_W'(a), kts_pkg::VID_W'($urandom));
			end else if (pick < 97) begin
				send_cmd(KIND_UNUSED, kts_pkg::VID_W'($urandom), kts_pkg::VID_W'($urandom));
			end else begin
				send_cmd(kts_pkg::KIND_CLEAR, kts_pkg::VID_W'($urandom),
					kts_pkg::VID_W'($urandom));
			end
		end
		if (hold_before_sort) drain();
		send_cmd(kts_pkg::KIND_SORT, kts_pkg::VID_W'($urandom), kts_pkg::VID_W'($urandom));
	endtask

	row_t dir_rows[$];

	function automatic row_t mk_cmd(logic [kts_pkg::KIND_W-1:0] k,
			logic [kts_pkg::VID_W-1:0] s, logic [kts_pkg::VID_W-1:0] d, bit typed,
			logic [kts_pkg::STATUS_W-1:0] st);
		row_t r;
		r.is_cfg = 0;
		r.cfg_val = '0;
		r.k = k;
		r.s = s;
		r.d = d;
		r.typed = typed;
		r.st = st;
		return r;
	endfunction

	function automatic row_t mk_cfg(logic [kts_pkg::CFG_W-1:0] v);
		row_t r;
		r = mk_cmd(kts_pkg::KIND_ADD, '0, '0, 0, kts_pkg::ST_ADDED);
		r.is_cfg = 1;
		r.cfg_val = v;
		return r;
	endfunction

	initial begin
		int prior_size;
		count_reg = kts_pkg::CFG_W'(NV);
		wipe_graph();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset state, extremes, every kind, each corner
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_SORT, 0, 0, 0, kts_pkg::ST_SORTED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 63, 0, 1, kts_pkg::ST_ADDED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 0, 63, 1, kts_pkg::ST_ADDED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_SORT, 0, 0, 1, kts_pkg::ST_CYCLE)); // loop
		dir_rows.push_back(mk_cmd(KIND_UNUSED, 63, 63, 0, kts_pkg::ST_ADDED));     // ignored
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_CLEAR, 63, 63, 1, kts_pkg::ST_CLEARED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 0, 0, 1, kts_pkg::ST_ADDED));  // self-loop
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_SORT, 0, 0, 1, kts_pkg::ST_CYCLE));
		dir_rows.push_back(mk_cfg(5));                                  // write also clears
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 5, 0, 1, kts_pkg::ST_INVALID));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 0, 63, 1, kts_pkg::ST_INVALID));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 3, 1, 0, kts_pkg::ST_ADDED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 3, 1, 0, kts_pkg::ST_ADDED));  // duplicate
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 1, 4, 0, kts_pkg::ST_ADDED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 3, 0, 0, kts_pkg::ST_ADDED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_SORT, 0, 0, 0, kts_pkg::ST_SORTED));
		dir_rows.push_back(mk_cfg(0));                                  // acts as one vertex
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 0, 1, 1, kts_pkg::ST_INVALID));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_SORT, 42, 21, 0, kts_pkg::ST_SORTED));
		dir_rows.push_back(mk_cfg(127));                                // clamps to max count
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 42, 21, 1, kts_pkg::ST_ADDED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_ADD, 21, 42, 1, kts_pkg::ST_ADDED));
		dir_rows.push_back(mk_cmd(kts_pkg::KIND_SORT, 0, 0, 1, kts_pkg::ST_CYCLE));
		dir_rows.push_back(mk_cfg(64));

		gap_pct = 12;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_count(dir_rows[i].cfg_val);
			end else begin
				prior_size = pending_beats.size();
				send_cmd(dir_rows[i].k, dir_rows[i].s, dir_rows[i].d);
				// typed status stands in for the model on single-beat rows
				if (dir_rows[i].typed && pending_beats.size() == prior_size + 1)
					pending_beats[pending_beats.size() - 1].st = dir_rows[i].st;
			end
		end

		// fill the edge store past its limit on a tiny graph
		write_count(3);
		for (int i = 0; i < NE + 3; i++)
			send_cmd(kts_pkg::KIND_ADD, kts_pkg::VID_W'($urandom_range(2)),
				kts_pkg::VID_W'($urandom_range(2)));
		send_cmd(kts_pkg::KIND_SORT, '0, '0);

		// random graphs under three sender idling modes
		for (int mode = 0; mode < 3; mode++) begin
			gap_pct = (mode == 0) ? 12 : (mode == 1) ? 75 : 0;
			graph_phase(mode == 0 ? 7'd1 : mode == 1 ? 7'd0 : 7'd127, mode == 1);
			graph_phase(7'd64, 0);
			while (items_sent < 300 + 65 * mode) begin
				if ($urandom_range(3) == 0)
					graph_phase(kts_pkg::CFG_W'($urandom_range(NV, 2)), 0);
				else
					graph_phase(kts_pkg::CFG_W'($urandom_range(10, 1)), 0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d commands, %0d sorts, %0d result beats", items_sent, sorts_done,
			beats_seen);
		$display("vertex counts 0, 1, 3, 5, 64, 127 and random; store full, cycles, bad endpoints");
		if (errors == 0 && pending_beats.size() == 0)
			$display("kahn_topological_sorter_top_tb passed");
		else
			$display("kahn_topological_sorter_top_tb failed");
		$finish;
	end

endmodule

>>> kahn_topological_sorter_top.f
src/kts_pkg.sv
src/kts_step_unit.sv
src/kts_graph_mem.sv
src/kts_sort_mem.sv
src/kahn_topological_sorter_top.sv
sim/kahn_topological_sorter_top_tb.sv
